// ----- design/text_console_engine_macros.svh -----
// ----------------------------------------------------------------------------
// text console engine assertion macros
// shared concurrent assertion forms, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_ENGINE_MACROS_SVH
`define TEXT_CONSOLE_ENGINE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define TCE_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("text_console_engine: implication check failed");

`define TCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("text_console_engine: next cycle check failed");

`else

`define TCE_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)

`define TCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- design/tce_pkg.sv -----
// ----------------------------------------------------------------------------
// tce_pkg
// shared constants, request and control codes, controller interface structs
// ----------------------------------------------------------------------------
package tce_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;
  localparam int TBL_W       = 7;

  localparam logic [2:0] REQ_PRINT  = 3'd0;
  localparam logic [2:0] REQ_KEY    = 3'd1;
  localparam logic [2:0] REQ_SETCUR = 3'd2;
  localparam logic [2:0] REQ_SCROLL = 3'd3;
  localparam logic [2:0] REQ_READ   = 3'd4;

  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_FF    = 8'd12;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_BLANK = 8'd32;
  localparam logic [7:0] CH_FIRST = 8'd32;
  localparam logic [7:0] CH_LAST  = 8'd126;

  localparam logic [1:0] CFG_FG = 2'd0;
  localparam logic [1:0] CFG_BG = 2'd1;

  localparam logic [3:0] FG_RESET = 4'd15;
  localparam logic [3:0] BG_RESET = 4'd0;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic addr;
    logic mem;
    logic clr_init;
    logic sweep_init;
    logic sweep_step;
    logic out_load;
  } tce_cmd_t;

  typedef struct packed {
    logic need_sweep;
    logic sweep_last;
    logic out_free;
  } tce_stat_t;

endpackage

// ----- design/tce_ctrl.sv -----
// ----------------------------------------------------------------------------
// tce_ctrl
// request sequencer: decode, address, memory access, screen sweep, result
// ----------------------------------------------------------------------------
module tce_ctrl import tce_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  tce_stat_t st,
  output tce_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_EXEC, S_ADDR, S_MEM, S_SWINIT, S_SWEEP, S_DRAIN, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   boot_r, boot_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    boot_nxt  = boot_r;
    unique case (state_r)
      S_INIT: begin
        cmd.clr_init = 1'b1;
        boot_nxt     = 1'b1;
        state_nxt    = S_SWEEP;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_ADDR;
      end
      S_ADDR: begin
        cmd.addr  = 1'b1;
        state_nxt = S_MEM;
      end
      S_MEM: begin
        cmd.mem   = 1'b1;
        state_nxt = st.need_sweep ? S_SWINIT : S_DONE;
      end
      S_SWINIT: begin
        cmd.sweep_init = 1'b1;
        state_nxt      = S_SWEEP;
      end
      S_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (st.sweep_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        boot_nxt  = 1'b0;
        state_nxt = boot_r ? S_IDLE : S_DONE;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      boot_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      boot_r  <= boot_nxt;
    end
  end

endmodule

// ----- design/tce_datapath.sv -----
// ----------------------------------------------------------------------------
// tce_datapath
// cursor, mark, row table, colour registers, screen memory and sweep engine
// ----------------------------------------------------------------------------
module tce_datapath import tce_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  tce_cmd_t    cmd,
  output tce_stat_t   st,
  input  logic [2:0]  in_req_type,
  input  logic [7:0]  in_char_code,
  input  logic [4:0]  in_line,
  input  logic [6:0]  in_column,
  input  logic [4:0]  in_scroll_count,
  input  logic        in_scroll_up,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_status,
  output logic [4:0]  out_cursor_line,
  output logic [6:0]  out_cursor_column,
  output logic [11:0] out_cursor_position,
  output logic [15:0] out_cell_data
);

  localparam int RW       = $clog2(ROWS + 1);
  localparam int CW       = $clog2(COLUMNS + 1);
  localparam int CW1      = CW + 1;
  localparam int TI       = $clog2(ROWS);
  localparam int DEPTH    = ROWS * COLUMNS;
  localparam int AW       = $clog2(DEPTH);
  localparam int COPY_END = (ROWS - 1) * COLUMNS;
  localparam int PW       = $clog2(DEPTH + COLUMNS + 1) + 1;

  // latched request
  logic [2:0] req_r;
  logic [7:0] ch_r;
  logic [4:0] ln_r;
  logic [6:0] col_r;
  logic [4:0] cnt_r;
  logic       up_r;

  logic [3:0] fg_r, bg_r;

  logic [RW-1:0] cur_row_r, mark_row_r;
  logic [CW-1:0] cur_col_r, mark_col_r;
  logic [TBL_W-1:0] tbl_r [ROWS];

  // per-request decisions
  logic          cw_en_r, rd_en_r, status_r, need_sweep_r, sw_copy_r;
  logic [RW-1:0] tgt_row_r, sw_k_r;
  logic [CW-1:0] tgt_col_r;
  logic [15:0]   cw_data_r;
  logic [AW-1:0] addr_r;

  // screen memory
  logic [15:0]   mem [DEPTH];
  logic [15:0]   rd_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [15:0]   mem_wd;

  // sweep engine
  logic [AW-1:0] dptr_r, sptr_r, pend_addr_r;
  logic [CW-1:0] scol_r;
  logic [RW-1:0] srow_r, shift_r, srow_init;
  logic [15:0]   fill_r;
  logic          copy_r, pend_valid_r, pend_copy_r, sw_in_copy;

  // output register
  logic          out_valid_r, ost_r;
  logic [4:0]    oline_r;
  logic [6:0]    ocol_r;
  logic [11:0]   opos_r;
  logic [15:0]   odata_r;
  logic [PW-1:0] pos;

  // decode results
  logic [RW-1:0]    row_n, mrow_n, tw_row, kq, scr_k, nr, br;
  logic [CW-1:0]    col_n, mcol_n, tgt_col;
  logic [RW-1:0]    tgt_row;
  logic [TBL_W-1:0] tw_val, tv, tvc;
  logic [CW1-1:0]   nc, cc_inc, tab_c;
  logic [7:0]       cw_ch;
  logic             tw_en, tclr, cw_en, rd_en, sw_en, sw_copy, stat;
  logic             scr_en, scr_up, printable, back_ok;

  assign kq = (cnt_r > 5'(ROWS)) ? RW'(ROWS) : RW'(cnt_r);
  assign printable = (ch_r >= CH_FIRST) && (ch_r <= CH_LAST);
  assign cc_inc = CW1'(cur_col_r) + CW1'(1);
  assign tab_c = (CW1'(cur_col_r) & ~CW1'(7)) + CW1'(8);
  assign br = cur_row_r - RW'(1);
  assign tv = tbl_r[TI'(br)];
  assign tvc = ({1'b0, tv} >= 8'(COLUMNS)) ? TBL_W'(COLUMNS - 1) : tv;
  assign back_ok = ((mark_row_r == cur_row_r) && (cur_col_r > mark_col_r)) ||
                   ((mark_row_r < cur_row_r) && (cur_col_r != '0));

  always_comb begin
    row_n   = cur_row_r;
    col_n   = cur_col_r;
    mrow_n  = mark_row_r;
    mcol_n  = mark_col_r;
    tw_en   = 1'b0;
    tw_row  = cur_row_r;
    tw_val  = '0;
    tclr    = 1'b0;
    cw_en   = 1'b0;
    tgt_row = cur_row_r;
    tgt_col = cur_col_r;
    cw_ch   = ch_r;
    rd_en   = 1'b0;
    sw_en   = 1'b0;
    sw_copy = 1'b0;
    stat    = 1'b0;
    scr_en  = 1'b0;
    scr_k   = kq;
    scr_up  = up_r;
    nr      = cur_row_r;
    nc      = cc_inc;
    unique case (req_r)
      REQ_PRINT, REQ_KEY: begin
        if (printable) begin
          cw_en = (cur_row_r < RW'(ROWS)) && (cur_col_r < CW'(COLUMNS));
          if (cc_inc > CW1'(COLUMNS - 1) && cur_row_r < RW'(ROWS)) begin
            nr = cur_row_r + RW'(1);
            nc = '0;
          end
          if (nr >= RW'(ROWS)) begin
            scr_en = 1'b1;
            scr_k  = RW'(1);
            scr_up = 1'b0;
          end else begin
            row_n  = nr;
            col_n  = CW'(nc);
            tw_en  = 1'b1;
            tw_row = nr;
            tw_val = TBL_W'(nc);
          end
        end else begin
          unique case (ch_r)
            CH_BS: begin
              if (back_ok) begin
                col_n   = cur_col_r - CW'(1);
                tw_en   = (cur_row_r < RW'(ROWS));
                tw_val  = TBL_W'(cur_col_r - CW'(1));
                cw_en   = (cur_row_r < RW'(ROWS));
                tgt_col = cur_col_r - CW'(1);
                cw_ch   = CH_BLANK;
              end else if (mark_row_r < cur_row_r) begin
                row_n   = br;
                col_n   = CW'(tvc);
                tw_en   = 1'b1;
                tw_row  = br;
                tw_val  = tvc;
                cw_en   = 1'b1;
                tgt_row = br;
                tgt_col = CW'(tvc);
                cw_ch   = CH_BLANK;
              end
            end
            CH_TAB: begin
              if (CW1'(cur_col_r) + CW1'(8) < CW1'(COLUMNS - 1)) begin
                nc = tab_c;
              end else begin
                nc = CW1'(COLUMNS - 1);
              end
              col_n  = CW'(nc);
              tw_en  = (cur_row_r < RW'(ROWS));
              tw_val = TBL_W'(nc);
            end
            CH_LF: begin
              if (cur_row_r < RW'(ROWS - 1)) begin
                row_n  = cur_row_r + RW'(1);
                col_n  = '0;
                tw_en  = 1'b1;
                tw_row = cur_row_r + RW'(1);
              end else begin
                scr_en = 1'b1;
                scr_k  = RW'(1);
                scr_up = 1'b0;
              end
            end
            CH_FF: begin
              sw_en = 1'b1;
              tclr  = 1'b1;
            end
            CH_CR: begin
              col_n = '0;
              tw_en = (cur_row_r < RW'(ROWS));
            end
            default: ;
          endcase
        end
      end
      REQ_SETCUR: begin
        if ({1'b0, col_r} > 8'(COLUMNS) || ln_r > 5'(ROWS)) begin
          stat = 1'b1;
        end else begin
          row_n = RW'(ln_r);
          col_n = CW'(col_r);
        end
      end
      REQ_SCROLL: begin
        scr_en = 1'b1;
      end
      REQ_READ: begin
        if (ln_r < 5'(ROWS) && {1'b0, col_r} < 8'(COLUMNS)) begin
          rd_en   = 1'b1;
          tgt_row = RW'(ln_r);
          tgt_col = CW'(col_r);
        end else begin
          stat = 1'b1;
        end
      end
      default: ;
    endcase
    if (scr_en) begin
      row_n = RW'(ROWS) - scr_k;
      col_n = '0;
      if (scr_k <= mark_row_r) begin
        mrow_n = mark_row_r - scr_k;
      end else begin
        mrow_n = '0;
        mcol_n = '0;
      end
      if (!scr_up) begin
        sw_en   = 1'b1;
        sw_copy = 1'b1;
      end
    end
    if (req_r == REQ_PRINT) begin
      mrow_n = row_n;
      mcol_n = col_n;
    end
  end

  // request latch and configuration
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      req_r <= in_req_type;
      ch_r  <= in_char_code;
      ln_r  <= in_line;
      col_r <= in_column;
      cnt_r <= in_scroll_count;
      up_r  <= in_scroll_up;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r <= FG_RESET;
      bg_r <= BG_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_FG) fg_r <= cfg_data;
      if (cfg_index == CFG_BG) bg_r <= cfg_data;
    end
  end

  // cursor, mark and row table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_row_r  <= '0;
      cur_col_r  <= '0;
      mark_row_r <= '0;
      mark_col_r <= '0;
      for (int i = 0; i < ROWS; i++) tbl_r[i] <= '0;
    end else if (cmd.exec) begin
      cur_row_r  <= row_n;
      cur_col_r  <= col_n;
      mark_row_r <= mrow_n;
      mark_col_r <= mcol_n;
      if (tclr) begin
        for (int i = 0; i < ROWS; i++) tbl_r[i] <= '0;
      end else if (tw_en && tw_row < RW'(ROWS)) begin
        tbl_r[TI'(tw_row)] <= tw_val;
      end
    end else if (cmd.sweep_step && shift_r != '0) begin
      for (int i = 0; i < ROWS - 1; i++) tbl_r[i] <= tbl_r[i + 1];
      tbl_r[ROWS - 1] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      cw_en_r      <= cw_en;
      rd_en_r      <= rd_en;
      status_r     <= stat;
      need_sweep_r <= sw_en;
      sw_copy_r    <= sw_copy;
      sw_k_r       <= scr_k;
      tgt_row_r    <= tgt_row;
      tgt_col_r    <= tgt_col;
      cw_data_r    <= {bg_r, fg_r, cw_ch};
    end
    if (cmd.addr) begin
      addr_r <= AW'(tgt_row_r) * AW'(COLUMNS) + AW'(tgt_col_r);
    end
  end

  // screen memory ports
  assign sw_in_copy = copy_r && (dptr_r < AW'(COPY_END));

  always_comb begin
    mem_we = 1'b0;
    mem_wa = addr_r;
    mem_wd = cw_data_r;
    if (pend_valid_r) begin
      mem_we = 1'b1;
      mem_wa = pend_addr_r;
      mem_wd = pend_copy_r ? rd_q : fill_r;
    end else if (cmd.mem && cw_en_r) begin
      mem_we = 1'b1;
    end
    mem_re = 1'b0;
    mem_ra = addr_r;
    if (cmd.sweep_step && sw_in_copy) begin
      mem_re = 1'b1;
      mem_ra = sptr_r;
    end else if (cmd.mem && rd_en_r) begin
      mem_re = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rd_q <= mem[mem_ra];
  end

  // sweep engine
  assign srow_init = (sw_k_r > RW'(ROWS - 1)) ? RW'(ROWS - 1) : sw_k_r;

  always_ff @(posedge clk) begin
    if (cmd.clr_init) begin
      dptr_r  <= '0;
      scol_r  <= '0;
      srow_r  <= '0;
      sptr_r  <= '0;
      copy_r  <= 1'b0;
      fill_r  <= '0;
      shift_r <= '0;
    end else if (cmd.sweep_init) begin
      dptr_r  <= '0;
      scol_r  <= '0;
      srow_r  <= srow_init;
      sptr_r  <= AW'(srow_init) * AW'(COLUMNS);
      copy_r  <= sw_copy_r;
      fill_r  <= {bg_r, fg_r, CH_BLANK};
      shift_r <= sw_copy_r ? sw_k_r : '0;
    end else if (cmd.sweep_step) begin
      dptr_r <= dptr_r + AW'(1);
      if (shift_r != '0) shift_r <= shift_r - RW'(1);
      if (scol_r == CW'(COLUMNS - 1)) begin
        scol_r <= '0;
        if (srow_r < RW'(ROWS - 1)) begin
          srow_r <= srow_r + RW'(1);
          sptr_r <= sptr_r + AW'(1);
        end else begin
          sptr_r <= sptr_r - AW'(COLUMNS - 1);
        end
      end else begin
        scol_r <= scol_r + CW'(1);
        sptr_r <= sptr_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else begin
      pend_valid_r <= cmd.sweep_step;
    end
    pend_addr_r <= dptr_r;
    pend_copy_r <= sw_in_copy;
  end

  // result register
  assign pos = PW'(cur_row_r) * PW'(COLUMNS) + PW'(cur_col_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.out_load) begin
      ost_r   <= status_r;
      oline_r <= 5'(cur_row_r);
      ocol_r  <= 7'(cur_col_r);
      opos_r  <= 12'(pos);
      odata_r <= rd_en_r ? rd_q : '0;
    end
  end

  assign st.need_sweep = need_sweep_r;
  assign st.sweep_last = (dptr_r == AW'(DEPTH - 1));
  assign st.out_free   = !out_valid_r || !out_stall;

  assign out_valid           = out_valid_r;
  assign out_status          = ost_r;
  assign out_cursor_line     = oline_r;
  assign out_cursor_column   = ocol_r;
  assign out_cursor_position = opos_r;
  assign out_cell_data       = odata_r;

endmodule

// ----- design/text_console_engine.sv -----
// simple requests pass the exec, address, memory and done states; a new one waits for idle
// scroll down, line wrap or line feed at the bottom and form feed add a sweep of the whole screen
// the sweep copies or fills one cell per cycle through the single memory read/write port pair
// reset is synchronous; afterwards a clearing pass zeroes the screen
// the input stays stalled during the clearing pass; configuration writes are always taken
// ----------------------------------------------------------------------------
// text_console_engine
// text-mode console: character screen, cursor, mark, scrolling and cell reads
// ----------------------------------------------------------------------------
`include "text_console_engine_macros.svh"

module text_console_engine import tce_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_req_type,
  input  logic [7:0]  in_char_code,
  input  logic [4:0]  in_line,
  input  logic [6:0]  in_column,
  input  logic [4:0]  in_scroll_count,
  input  logic        in_scroll_up,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_status,
  output logic [4:0]  out_cursor_line,
  output logic [6:0]  out_cursor_column,
  output logic [11:0] out_cursor_position,
  output logic [15:0] out_cell_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data
);

  tce_cmd_t  cmd;
  tce_stat_t st;

  assign cfg_ready = 1'b1;

  tce_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  tce_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .st                  (st),
    .in_req_type         (in_req_type),
    .in_char_code        (in_char_code),
    .in_line             (in_line),
    .in_column           (in_column),
    .in_scroll_count     (in_scroll_count),
    .in_scroll_up        (in_scroll_up),
    .cfg_we              (cfg_valid && cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_cursor_line     (out_cursor_line),
    .out_cursor_column   (out_cursor_column),
    .out_cursor_position (out_cursor_position),
    .out_cell_data       (out_cell_data)
  );

  `TCE_ASSERT_NEXT(a_accept_then_busy, clk, rst_n, in_valid && !in_stall, in_stall)
  `TCE_ASSERT_IMPLY(a_no_overwrite, clk, rst_n, cmd.out_load, !out_valid || !out_stall)
  `TCE_ASSERT_IMPLY(a_row_range, clk, rst_n, out_valid, out_cursor_line <= 5'(ROWS))
  `TCE_ASSERT_IMPLY(a_sweep_stalls, clk, rst_n, cmd.sweep_step, in_stall && !cmd.out_load)

endmodule
